// ----- rtl/core/swpd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swpd_pkg
// Shared types, constants and helpers of the sync word packet deframer.
// ----------------------------------------------------------------------------
package swpd_pkg;

	localparam int BYTE_W        = 8;
	localparam int SYNC_BYTES    = 4;
	localparam int WORD_BYTES    = 4;
	localparam int PAYLOAD_BYTES = 16;
	localparam int STORE_DEPTH   = PAYLOAD_BYTES - 1;
	localparam int HIST_W        = (SYNC_BYTES - 1) * BYTE_W;
	localparam int HEADER_W      = SYNC_BYTES * BYTE_W;
	localparam int WORD_W        = WORD_BYTES * BYTE_W;
	localparam int INDEX_W       = $clog2(PAYLOAD_BYTES);
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 8;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SYNC_0     = 3'd0,
		REG_SYNC_1     = 3'd1,
		REG_SYNC_2     = 3'd2,
		REG_SYNC_3     = 3'd3,
		REG_BIG_ENDIAN = 3'd4
	} cfg_reg_t;

	// Packed so that the count word sits in the lowest bits
	typedef struct packed {
		word_t rate_z_bits;
		word_t rate_y_bits;
		word_t rate_x_bits;
		word_t packet_count;
	} packet_t;

	function automatic word_t assemble_word(input byte_t b0, input byte_t b1,
	                                        input byte_t b2, input byte_t b3,
	                                        input logic big_endian);
		word_t w;
		if (big_endian) begin
			w = {b0, b1, b2, b3};
		end else begin
			w = {b3, b2, b1, b0};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sync_word_packet_deframer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sync_word_packet_deframer
// Finds a configurable four-byte sync header in a byte stream and turns the
// sixteen payload bytes after it into one packet of four 32-bit words.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle unless the slave side stalls; each byte
// passes an input register, a single pass of compare and store logic, and,
// if it completes a packet, the result register, from which the packet then
// shows on the master side until the sink takes it. Only a result
// waiting in the output register while the sink holds tready low stalls the
// slave side. Headers are matched on a sliding window only while hunting;
// header bytes inside a payload are stored as data. Registers 0..3 hold the
// header bytes in arrival order, register 4 selects big-endian (1) or
// little-endian (0) word assembly; write them only while the block is idle.
// ----------------------------------------------------------------------------
module sync_word_packet_deframer import swpd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// slave side, tdata[7:0] = data_byte
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [BYTE_W-1:0]      s_tdata,
	// master side, tdata[31:0] = packet_count, [63:32] = rate_x_bits,
	// [95:64] = rate_y_bits, [127:96] = rate_z_bits
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [4*WORD_W-1:0]         m_tdata,
	// configuration write channel
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	byte_t   sync_q [SYNC_BYTES];
	logic    big_endian_q;

	logic    valid_s1;
	byte_t   byte_s1;
	logic    valid_s2;
	packet_t packet_s2;

	logic    advance;
	logic    step;
	logic    hunt_step;
	logic    found;
	logic    collecting;
	logic    done;
	packet_t packet;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYNC_BYTES; i++) begin
				sync_q[i] <= '0;
			end
			big_endian_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SYNC_0:     sync_q[0]    <= cfg_data[BYTE_W-1:0];
				REG_SYNC_1:     sync_q[1]    <= cfg_data[BYTE_W-1:0];
				REG_SYNC_2:     sync_q[2]    <= cfg_data[BYTE_W-1:0];
				REG_SYNC_3:     sync_q[3]    <= cfg_data[BYTE_W-1:0];
				REG_BIG_ENDIAN: big_endian_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The output register frees up when empty or when its result is taken
	assign advance   = !valid_s2 || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;
	assign hunt_step = step && !collecting;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	swpd_sync_hunt u_hunt (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (hunt_step),
		.data_byte (byte_s1),
		.header    ({sync_q[0], sync_q[1], sync_q[2], sync_q[3]}),
		.found     (found)
	);

	swpd_payload u_payload (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.found      (found),
		.big_endian (big_endian_q),
		.collecting (collecting),
		.done       (done),
		.packet     (packet)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			packet_s2 <= packet;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = packet_s2;

endmodule
`default_nettype wire

// ----- rtl/core/swpd_sync_hunt.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swpd_sync_hunt
// Sliding byte history and header compare while hunting for the sync word.
// ----------------------------------------------------------------------------
module swpd_sync_hunt import swpd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire byte_t               data_byte,
	input  wire logic [HEADER_W-1:0] header,
	output logic                     found
);

	logic [HIST_W-1:0] recent_q;
	logic [1:0]        fill_q;
	logic              full;

	assign full  = (fill_q == 2'(SYNC_BYTES - 1));
	assign found = full && ({recent_q, data_byte} == header);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			fill_q   <= '0;
		end else if (step) begin
			if (found) begin
				// empty the history, the next header must arrive whole
				recent_q <= '0;
				fill_q   <= '0;
			end else begin
				recent_q <= {recent_q[HIST_W-BYTE_W-1:0], data_byte};
				if (!full) begin
					fill_q <= fill_q + 2'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/swpd_payload.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swpd_payload
// Payload byte collection after a header, and packet word assembly.
// ----------------------------------------------------------------------------
module swpd_payload import swpd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire byte_t data_byte,
	input  wire logic  found,
	input  wire logic  big_endian,
	output logic       collecting,
	output logic       done,
	output packet_t    packet
);

	logic               collecting_q;
	logic [INDEX_W-1:0] index_q;
	byte_t              store_q [STORE_DEPTH];
	byte_t              full_bytes [PAYLOAD_BYTES];
	logic               last_byte;

	assign collecting = collecting_q;
	assign last_byte  = (index_q == INDEX_W'(STORE_DEPTH));
	assign done       = step && collecting_q && last_byte;

	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			full_bytes[i] = store_q[i];
		end
		full_bytes[STORE_DEPTH] = data_byte;
	end

	assign packet.packet_count = assemble_word(full_bytes[0], full_bytes[1],
		full_bytes[2], full_bytes[3], big_endian);
	assign packet.rate_x_bits  = assemble_word(full_bytes[4], full_bytes[5],
		full_bytes[6], full_bytes[7], big_endian);
	assign packet.rate_y_bits  = assemble_word(full_bytes[8], full_bytes[9],
		full_bytes[10], full_bytes[11], big_endian);
	assign packet.rate_z_bits  = assemble_word(full_bytes[12], full_bytes[13],
		full_bytes[14], full_bytes[15], big_endian);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			index_q      <= '0;
		end else if (step) begin
			if (!collecting_q) begin
				if (found) begin
					collecting_q <= 1'b1;
					index_q      <= '0;
				end
			end else if (last_byte) begin
				collecting_q <= 1'b0;
				index_q      <= '0;
			end else begin
				index_q <= index_q + INDEX_W'(1);
			end
		end
	end

	// Shift line: after the fifteenth payload byte, entry 0 holds the first one
	always_ff @(posedge clk) begin
		if (step && collecting_q && !last_byte) begin
			for (int i = 0; i < STORE_DEPTH - 1; i++) begin
				store_q[i] <= store_q[i+1];
			end
			store_q[STORE_DEPTH-1] <= data_byte;
		end
	end

endmodule
`default_nettype wire
